/* hw/rtl/ac_remote_frame_encoder_defines.svh */
// ----------------------------------------------------------------------------
// ac remote frame encoder assertion macros
// concurrent assertion shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef AC_REMOTE_FRAME_ENCODER_DEFINES_SVH
`define AC_REMOTE_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication
`define AC_ENC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ac_enc assertion failed");

// next-cycle implication
`define AC_ENC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ac_enc assertion failed");

`endif

/* hw/rtl/ac_enc_pkg.sv */
// ----------------------------------------------------------------------------
// ac_enc_pkg
// shared types, codes, base frame and byte helpers of the frame encoder
// ----------------------------------------------------------------------------
package ac_enc_pkg;

    // command kinds
    localparam logic [2:0] KIND_TEMP    = 3'd0;
    localparam logic [2:0] KIND_FAN     = 3'd1;
    localparam logic [2:0] KIND_BOOST   = 3'd2;
    localparam logic [2:0] KIND_SWING   = 3'd3;
    localparam logic [2:0] KIND_DISPLAY = 3'd4;
    localparam logic [2:0] KIND_HEALTH  = 3'd5;
    localparam logic [2:0] KIND_POWER   = 3'd6;
    localparam logic [2:0] KIND_EMIT    = 3'd7;

    // power modes
    localparam logic [1:0] PWR_ON          = 2'd0;
    localparam logic [1:0] PWR_TURNING_ON  = 2'd1;
    localparam logic [1:0] PWR_TURNING_OFF = 2'd2;

    // fan speeds
    localparam logic [1:0] FAN_SPEED_AUTO = 2'd0;
    localparam logic [1:0] FAN_SPEED_LOW  = 2'd1;
    localparam logic [1:0] FAN_SPEED_MID  = 2'd2;
    localparam logic [1:0] FAN_SPEED_HIGH = 2'd3;

    localparam logic [4:0] TEMP_MIN   = 5'd16;
    localparam logic [4:0] TEMP_MAX   = 5'd31;
    localparam int         FRAME_LEN  = 14;
    localparam logic [3:0] LAST_INDEX = 4'(FRAME_LEN - 1);
    localparam int         QUEUE_DEPTH = 2;

    localparam logic [7:0] FRAME_TEMPLATE [FRAME_LEN] = '{
        8'hC4, 8'hD3, 8'h64, 8'h80, 8'h00, 8'h26, 8'hC0,
        8'hF0, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00
    };

    // settings captured for one frame
    typedef struct packed {
        logic [1:0] power;
        logic [4:0] temp;
        logic [1:0] fan;
        logic       boost;
        logic       swing;
        logic       display;
        logic       health;
    } settings_t;

    // front to queue
    typedef struct packed {
        logic      push;
        settings_t data;
    } push_req_t;

    // queue head to back
    typedef struct packed {
        logic      valid;
        settings_t data;
    } head_t;

    function automatic logic [3:0] rev4(input logic [3:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    endfunction

    // frame byte at a position 0..12 with the settings patched in
    function automatic logic [7:0] frame_byte(input settings_t s, input logic [3:0] idx);
        logic [7:0] b;
        logic [3:0] diff;
        logic [2:0] fan_bits;
        b    = FRAME_TEMPLATE[idx];
        diff = 4'(TEMP_MAX - s.temp);
        unique case (s.fan)
            FAN_SPEED_AUTO: fan_bits = 3'b000;
            FAN_SPEED_LOW:  fan_bits = 3'b010;
            FAN_SPEED_MID:  fan_bits = 3'b110;
            FAN_SPEED_HIGH: fan_bits = 3'b101;
            default:        fan_bits = 3'b000;
        endcase
        unique case (idx)
            4'd5:
            begin
                b[1] = !s.display;
                if (!s.boost)
                begin
                    b[5] = (s.power != PWR_TURNING_OFF);
                end
            end
            4'd6:
            begin
                b[3] = s.health;
                b[1] = s.boost;
            end
            4'd7:
            begin
                b[7:4] = rev4(diff);
            end
            4'd8:
            begin
                b[7:5] = fan_bits;
                b[4:2] = {3{s.swing}};
                if (!s.boost)
                begin
                    b[1] = (s.power != PWR_ON);
                end
            end
            default:
            begin
                b = FRAME_TEMPLATE[idx];
            end
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/ac_enc_cmd_if.sv */
// ----------------------------------------------------------------------------
// ac_enc_cmd_if
// command channel: kind and operand with valid/ready
// ----------------------------------------------------------------------------
interface ac_enc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [4:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

/* hw/rtl/ac_enc_frame_if.sv */
// ----------------------------------------------------------------------------
// ac_enc_frame_if
// frame channel: one encoded byte per word with valid/ready
// ----------------------------------------------------------------------------
interface ac_enc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_index, output last_byte,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                    output ready);
endinterface

/* hw/rtl/ac_enc_front.sv */
// ----------------------------------------------------------------------------
// ac_enc_front
// takes commands, keeps the settings, queues a snapshot on emit
// ----------------------------------------------------------------------------
module ac_enc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    ac_enc_cmd_if.sink            cmd,
    input  logic                  full,
    output ac_enc_pkg::push_req_t push_req
);

    logic [1:0] power_reg, power_next;
    logic [4:0] temp_reg, temp_next;
    logic [1:0] fan_reg, fan_next;
    logic       boost_reg, boost_next;
    logic       swing_reg, swing_next;
    logic       display_reg, display_next;
    logic       health_reg, health_next;
    logic       accept;
    logic       flag;

    assign cmd.ready = !full;
    assign accept    = cmd.valid && !full;
    assign flag      = (cmd.value != 5'd0);

    always_comb
    begin
        power_next   = power_reg;
        temp_next    = temp_reg;
        fan_next     = fan_reg;
        boost_next   = boost_reg;
        swing_next   = swing_reg;
        display_next = display_reg;
        health_next  = health_reg;
        if (accept)
        begin
            unique case (cmd.kind)
                ac_enc_pkg::KIND_TEMP:
                begin
                    temp_next  = (cmd.value < ac_enc_pkg::TEMP_MIN) ?
                                 ac_enc_pkg::TEMP_MIN : cmd.value;
                    boost_next = 1'b0;
                    power_next = ac_enc_pkg::PWR_ON;
                end
                ac_enc_pkg::KIND_FAN:
                begin
                    fan_next   = (cmd.value > 5'(ac_enc_pkg::FAN_SPEED_HIGH)) ?
                                 ac_enc_pkg::FAN_SPEED_AUTO : cmd.value[1:0];
                    boost_next = 1'b0;
                    power_next = ac_enc_pkg::PWR_ON;
                end
                ac_enc_pkg::KIND_BOOST:
                begin
                    boost_next = flag;
                    if (flag)
                    begin
                        temp_next = ac_enc_pkg::TEMP_MIN;
                        fan_next  = ac_enc_pkg::FAN_SPEED_AUTO;
                    end
                    power_next = ac_enc_pkg::PWR_ON;
                end
                ac_enc_pkg::KIND_SWING:
                begin
                    swing_next = flag;
                    power_next = ac_enc_pkg::PWR_ON;
                end
                ac_enc_pkg::KIND_DISPLAY:
                begin
                    display_next = flag;
                    power_next   = ac_enc_pkg::PWR_ON;
                end
                ac_enc_pkg::KIND_HEALTH:
                begin
                    health_next = flag;
                    power_next  = ac_enc_pkg::PWR_ON;
                end
                ac_enc_pkg::KIND_POWER:
                begin
                    // unknown power codes leave everything alone
                    if (cmd.value <= 5'(ac_enc_pkg::PWR_TURNING_OFF))
                    begin
                        power_next = cmd.value[1:0];
                        if (cmd.value[1:0] != ac_enc_pkg::PWR_ON)
                        begin
                            boost_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    power_next = power_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        push_req.push         = accept && (cmd.kind == ac_enc_pkg::KIND_EMIT);
        push_req.data.power   = power_reg;
        push_req.data.temp    = temp_reg;
        push_req.data.fan     = fan_reg;
        push_req.data.boost   = boost_reg;
        push_req.data.swing   = swing_reg;
        push_req.data.display = display_reg;
        push_req.data.health  = health_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg   <= ac_enc_pkg::PWR_TURNING_OFF;
            temp_reg    <= ac_enc_pkg::TEMP_MIN;
            fan_reg     <= ac_enc_pkg::FAN_SPEED_AUTO;
            boost_reg   <= 1'b0;
            swing_reg   <= 1'b0;
            display_reg <= 1'b0;
            health_reg  <= 1'b0;
        end
        else
        begin
            power_reg   <= power_next;
            temp_reg    <= temp_next;
            fan_reg     <= fan_next;
            boost_reg   <= boost_next;
            swing_reg   <= swing_next;
            display_reg <= display_next;
            health_reg  <= health_next;
        end
    end

endmodule

/* hw/rtl/ac_enc_queue.sv */
// ----------------------------------------------------------------------------
// ac_enc_queue
// small fifo of settings snapshots between front and back
// ----------------------------------------------------------------------------
module ac_enc_queue #(
    parameter int DEPTH = ac_enc_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ac_enc_pkg::push_req_t push_req,
    input  logic                  pop,
    output logic                  full,
    output ac_enc_pkg::head_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ac_enc_pkg::settings_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign do_push    = push_req.push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req.data;
        end
    end

endmodule

/* hw/rtl/ac_enc_back.sv */
// ----------------------------------------------------------------------------
// ac_enc_back
// serializes one snapshot into fourteen frame bytes with running checksum
// ----------------------------------------------------------------------------
module ac_enc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ac_enc_pkg::head_t head,
    output logic              pop,
    ac_enc_frame_if.source    frame
);

    logic [3:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [3:0] out_idx_reg, out_idx_next;
    logic       out_last_reg, out_last_next;
    logic       advance;
    logic       at_last;
    logic [7:0] body_byte;

    assign advance   = !out_valid_reg || frame.ready;
    assign at_last   = (idx_reg == ac_enc_pkg::LAST_INDEX);
    assign body_byte = ac_enc_pkg::frame_byte(head.data, idx_reg);
    assign pop       = advance && head.valid && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                out_idx_next = idx_reg;
                if (at_last)
                begin
                    // checksum word closes the frame
                    out_byte_next = ac_enc_pkg::rev8(sum_reg);
                    out_last_next = 1'b1;
                    idx_next      = '0;
                    sum_next      = '0;
                end
                else
                begin
                    out_byte_next = body_byte;
                    out_last_next = 1'b0;
                    idx_next      = idx_reg + 1'b1;
                    sum_next      = sum_reg + ac_enc_pkg::rev8(body_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.byte_index = out_idx_reg;
    assign frame.last_byte  = out_last_reg;

endmodule

/* hw/rtl/ac_remote_frame_encoder.sv */
// ----------------------------------------------------------------------------
// ac_remote_frame_encoder
// air conditioner settings store and 14-byte remote frame encoder
// ----------------------------------------------------------------------------
// Set commands (temperature, fan, boost, swing, display, health, power) are
// taken one per cycle unless the queue is full and update the stored settings
// at once; they produce no word on the frame channel. An emit command takes a
// snapshot of the settings into a short queue (QUEUE_DEPTH entries) and the
// serializer behind it sends the frame as fourteen words, bytes 0 to 12 and
// then the checksum, one word per cycle while the sink keeps ready high, so
// back-to-back emits stream without gaps. The serializer, one byte per cycle,
// sets the frame rate; commands stall only while the snapshot queue is full.
// Nothing needs clearing after reset: the block is ready in the first cycle.
// ----------------------------------------------------------------------------
module ac_remote_frame_encoder #(
    parameter int QUEUE_DEPTH = ac_enc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    ac_enc_cmd_if.sink     cmd,
    ac_enc_frame_if.source frame
);

    // snapshot handoff between command side and serializer
    ac_enc_pkg::push_req_t push_req;
    ac_enc_pkg::head_t     head;
    logic                  full;
    logic                  pop;

    // front: decodes commands, owns the settings registers
    ac_enc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .full     (full),
        .push_req (push_req)
    );

    // queue: decouples command intake from frame output stalls
    ac_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (push_req),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    // back: patches the base frame, accumulates checksum, registers output word
    ac_enc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .frame (frame)
    );

endmodule

/* hw/rtl/ac_enc_checker.sv */
// ----------------------------------------------------------------------------
// ac_enc_checker
// port-level checks of the frame encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "ac_remote_frame_encoder_defines.svh"

module ac_enc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] frame_byte,
    input logic [3:0] byte_index,
    input logic       last_byte
);

    // stalled word holds
    `AC_ENC_ASSERT_NEXT(a_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_byte) && $stable(byte_index) && $stable(last_byte))

    // last flag marks exactly the checksum position
    `AC_ENC_ASSERT_NOW(a_last, frame_valid, last_byte == (byte_index == ac_enc_pkg::LAST_INDEX))

    // frame position stays in range
    `AC_ENC_ASSERT_NOW(a_range, frame_valid, byte_index <= ac_enc_pkg::LAST_INDEX)

    // inside a frame the next byte follows right away
    `AC_ENC_ASSERT_NEXT(a_stream, frame_valid && frame_ready && !last_byte, frame_valid && (byte_index == $past(byte_index) + 4'd1))

endmodule

bind ac_remote_frame_encoder ac_enc_checker u_ac_enc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .byte_index  (frame.byte_index),
    .last_byte   (frame.last_byte)
);
